// ===== sv/nearest_palette_color_unit_defines.svh =====
// Assertion macros for the nearest palette color unit.
// Included by the module that carries concurrent assertions; no other dependencies.
`ifndef NEAREST_PALETTE_COLOR_UNIT_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checked property, ignored while reset is asserted.
`define NPC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("nearest palette color unit: assertion failed");
// Checked property, evaluated during reset as well.
`define NPC_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("nearest palette color unit: reset assertion failed");
`else
`define NPC_ASSERT(lbl, clk, rstn, prop)
`define NPC_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== sv/npc_pkg.sv =====
// Shared types and constants for the nearest palette color unit.
// No dependencies; used by npc_cell and nearest_palette_color_unit.
package npc_pkg;

  localparam int COLOR_W = 8;
  localparam int LABEL_W = 16;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int SQ_W    = 2 * COLOR_W;
  localparam int DIST_W  = 18;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // One item as it travels down the chain.
  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [SLOT_W-1:0]  slot;
    logic [LABEL_W-1:0] label;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } item_t;

  // Running best match carried along with a query.
  typedef struct packed {
    logic               have;
    logic [LABEL_W-1:0] label;
    logic [DIST_W-1:0]  distance;
  } best_t;

endpackage

// ===== sv/nearest_palette_color_unit.sv =====
// Nearest palette color search over a chain of palette cells.
// Depends on npc_pkg, npc_cell and nearest_palette_color_unit_defines.svh.
//
//  channel | direction | handshake          | contents
//  --------+-----------+--------------------+---------------------------------
//  in_     | input     | tvalid / tready    | load or query item
//  out_    | output    | tvalid / tready    | nearest label, distance, found
//  cfg_    | input     | cfg_we             | entry_count
//
// One item is accepted per cycle while the chain is not held; a query result is offered
// at the chain tail after two register stages per palette cell.
// Loads and queries travel the chain in order, so a query sees every earlier load.
// When a result is waiting and out_tready is low the whole chain holds.
// Synchronous active-low reset clears the valid bits and entry_count; the
// palette itself holds no reset value.
`include "nearest_palette_color_unit_defines.svh"
module nearest_palette_color_unit #(
  parameter int PALETTE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: entry_count.
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // slot[3:0], label[19:4], red[27:20], green[35:28], blue[43:36]
  input  logic        in_tuser,  // kind
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // best_label[15:0], best_distance[33:16]
  output logic        out_tuser  // found
);

  logic [npc_pkg::COUNT_W-1:0] entry_count_r;
  logic                        advance;

  npc_pkg::item_t item_chain [PALETTE_DEPTH+1];
  npc_pkg::best_t best_chain [PALETTE_DEPTH+1];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_we) begin
      entry_count_r <= cfg_wdata;
    end
  end

  // The chain moves unless a finished result is waiting to be taken.
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = advance;

  // Chain head: unpack the incoming item, start with no match.
  assign item_chain[0] = {in_tvalid, in_tuser, in_tdata[3:0], in_tdata[19:4],
                          in_tdata[27:20], in_tdata[35:28], in_tdata[43:36]};
  assign best_chain[0] = '0;

  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    npc_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .advance     (advance),
      .entry_count (entry_count_r),
      .item_in     (item_chain[i]),
      .best_in     (best_chain[i]),
      .item_out    (item_chain[i+1]),
      .best_out    (best_chain[i+1])
    );
  end

  // Chain tail: only queries produce a result.
  assign out_tvalid = item_chain[PALETTE_DEPTH].valid &&
                      item_chain[PALETTE_DEPTH].kind == npc_pkg::KIND_QUERY;
  assign out_tdata  = {6'b0, best_chain[PALETTE_DEPTH].distance,
                       best_chain[PALETTE_DEPTH].label};
  assign out_tuser  = best_chain[PALETTE_DEPTH].have;

  // A result without a match carries zero label and distance.
  `NPC_ASSERT(a_empty_zero, clk, rst_n, (out_tvalid && !out_tuser) |-> (out_tdata == 40'd0))
  // With a fixed nonzero count every query finds a match.
  `NPC_ASSERT(a_found_count, clk, rst_n, out_tvalid |-> (out_tuser == (entry_count_r != '0)))
  // Reset empties the chain.
  `NPC_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_tvalid)

endmodule

// ===== sv/npc_cell.sv =====
// One palette cell: holds a single entry, squares the color differences and
// updates the running best match. Depends on npc_pkg.
module npc_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [npc_pkg::COUNT_W-1:0]  entry_count,
  input  npc_pkg::item_t               item_in,
  input  npc_pkg::best_t               best_in,
  output npc_pkg::item_t               item_out,
  output npc_pkg::best_t               best_out
);

  // Stored palette entry.
  logic [npc_pkg::LABEL_W-1:0] ent_label_r;
  logic [npc_pkg::COLOR_W-1:0] ent_red_r;
  logic [npc_pkg::COLOR_W-1:0] ent_green_r;
  logic [npc_pkg::COLOR_W-1:0] ent_blue_r;

  // First stage: item, best so far, squared differences, entry label.
  npc_pkg::item_t              item1_r;
  npc_pkg::best_t              best1_r;
  logic                        hit1_r;
  logic [npc_pkg::LABEL_W-1:0] lab1_r;
  logic [npc_pkg::SQ_W-1:0]    sq_r_r, sq_g_r, sq_b_r;
  logic [npc_pkg::SQ_W-1:0]    sq_r_nxt, sq_g_nxt, sq_b_nxt;

  // Second stage: outputs toward the next cell.
  npc_pkg::item_t item2_r;
  npc_pkg::best_t best2_r;
  npc_pkg::best_t best2_nxt;

  logic                        slot_match;
  logic                        searched;
  logic [npc_pkg::DIST_W-1:0]  dist_sum;

  function automatic logic [npc_pkg::SQ_W-1:0] sq_diff(
    input logic [npc_pkg::COLOR_W-1:0] a,
    input logic [npc_pkg::COLOR_W-1:0] b
  );
    logic [npc_pkg::COLOR_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return npc_pkg::SQ_W'(d) * npc_pkg::SQ_W'(d);
  endfunction

  assign slot_match = (int'(item_in.slot) == CELL_INDEX);
  assign searched   = (int'(entry_count) > CELL_INDEX);

  // Squared component differences against the stored entry.
  always_comb begin
    sq_r_nxt = sq_diff(ent_red_r, item_in.red);
    sq_g_nxt = sq_diff(ent_green_r, item_in.green);
    sq_b_nxt = sq_diff(ent_blue_r, item_in.blue);
  end

  // Entry store: a load addressed to this cell overwrites it.
  always_ff @(posedge clk) begin
    if (advance && item_in.valid && item_in.kind == npc_pkg::KIND_LOAD && slot_match) begin
      ent_label_r <= item_in.label;
      ent_red_r   <= item_in.red;
      ent_green_r <= item_in.green;
      ent_blue_r  <= item_in.blue;
    end
  end

  // First stage registers; the item passes on unchanged.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item1_r.valid <= 1'b0;
    end else if (advance) begin
      item1_r.valid <= item_in.valid;
    end
    if (advance) begin
      item1_r.kind  <= item_in.kind;
      item1_r.slot  <= item_in.slot;
      item1_r.label <= item_in.label;
      item1_r.red   <= item_in.red;
      item1_r.green <= item_in.green;
      item1_r.blue  <= item_in.blue;
      lab1_r        <= ent_label_r;
      best1_r       <= best_in;
      hit1_r        <= searched && item_in.kind == npc_pkg::KIND_QUERY;
      sq_r_r        <= sq_r_nxt;
      sq_g_r        <= sq_g_nxt;
      sq_b_r        <= sq_b_nxt;
    end
  end

  // Distance sum and strict-less compare; ties keep the earlier entry.
  always_comb begin
    dist_sum = npc_pkg::DIST_W'(sq_r_r) + npc_pkg::DIST_W'(sq_g_r) +
               npc_pkg::DIST_W'(sq_b_r);
    best2_nxt = best1_r;
    if (hit1_r && (!best1_r.have || dist_sum < best1_r.distance)) begin
      best2_nxt.have     = 1'b1;
      best2_nxt.label    = lab1_r;
      best2_nxt.distance = dist_sum;
    end
  end

  // Second stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item2_r.valid <= 1'b0;
    end else if (advance) begin
      item2_r.valid <= item1_r.valid;
    end
    if (advance) begin
      item2_r.kind  <= item1_r.kind;
      item2_r.slot  <= item1_r.slot;
      item2_r.label <= item1_r.label;
      item2_r.red   <= item1_r.red;
      item2_r.green <= item1_r.green;
      item2_r.blue  <= item1_r.blue;
      best2_r       <= best2_nxt;
    end
  end

  assign item_out = item2_r;
  assign best_out = best2_r;

endmodule
